[rtl/uvd_pkg.sv]
// ---------------------------------------------------------------------------
// uvd_pkg
// Shared constants, codes and widths of the unique value deque.
// ---------------------------------------------------------------------------
package uvd_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int OUT_KEY_W  = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_HALTED = 3'd4
    } t_status;

endpackage

[rtl/unique_value_deque.sv]
// ---------------------------------------------------------------------------
// unique_value_deque
// Double-ended queue of keys with duplicate rejection and sticky halt.
// ---------------------------------------------------------------------------
// One word in, one word out. A push scans every held key through the single
// read port of the key memory, one key per cycle, then decides and writes; a
// pop reads the key at the new end of the queue, and a pop on an empty queue
// or an item after a halt goes straight to the result, each plus any wait for
// the output to be taken. The next word is taken as soon as the current
// result sits in the output register. The first refused word halts the block
// until reset; later words return status "halted" and leave the queue alone.
module unique_value_deque (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [uvd_pkg::IN_DATA_W-1:0]  i_s_tdata,   // value[31:0]
    input  logic [uvd_pkg::CMD_W-1:0]      i_s_tuser,   // command[1:0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [uvd_pkg::OUT_DATA_W-1:0] o_m_tdata    // status[2:0], count[7:3],
                                                        // front_value[39:8],
                                                        // back_value[71:40]
);
    import uvd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_POP    = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [KEY_WIDTH-1:0] r_key_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rd_key;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    t_status              r_status, n_status;
    logic [IDX_W-1:0]     r_front, n_front;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_halted, n_halted;
    logic [KEY_WIDTH-1:0] r_front_key, n_front_key;
    logic [KEY_WIDTH-1:0] r_back_key, n_back_key;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_cmp, n_cmp;
    logic                 r_dup, n_dup;
    logic                 r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_tdata, n_m_tdata;

    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     front_m1;
    logic [KEY_WIDTH+VALUE_W-1:0]   key_ext;
    logic [KEY_WIDTH-1:0]           key_in;
    t_cmd                           cmd_in;
    logic [CNT_W+COUNT_W-1:0]       cnt_ext;
    logic [KEY_WIDTH+OUT_KEY_W-1:0] front_ext;
    logic [KEY_WIDTH+OUT_KEY_W-1:0] back_ext;

    assign key_ext   = {KEY_WIDTH'(0), i_s_tdata};
    assign key_in    = key_ext[KEY_WIDTH-1:0];
    assign cmd_in    = t_cmd'(i_s_tuser);
    assign cnt_ext   = {COUNT_W'(0), r_count};
    assign front_ext = {OUT_KEY_W'(0), r_front_key};
    assign back_ext  = {OUT_KEY_W'(0), r_back_key};
    assign front_m1  = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - IDX_W'(1);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[wr_addr] <= r_key;
        end
        r_rd_key <= r_key_mem[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_status    = r_status;
        n_front     = r_front;
        n_count     = r_count;
        n_halted    = r_halted;
        n_front_key = r_front_key;
        n_back_key  = r_back_key;
        n_idx       = r_idx;
        n_cmp       = r_cmp;
        n_dup       = r_dup;
        n_m_valid   = r_m_valid & ~i_m_tready;
        n_m_tdata   = r_m_tdata;
        rd_addr     = r_front;
        wr_en       = 1'b0;
        wr_addr     = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd = cmd_in;
                    n_key = key_in;
                    n_idx = '0;
                    n_cmp = 1'b0;
                    n_dup = 1'b0;
                    if (r_halted) begin
                        n_status = ST_HALTED;
                        n_state  = S_FIN;
                    end else if (cmd_in == CMD_PUSH_FRONT || cmd_in == CMD_PUSH_BACK) begin
                        n_state = S_SCAN;
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_halted = 1'b1;
                        n_state  = S_FIN;
                    end else begin
                        n_status = ST_OK;
                        n_count  = r_count - CNT_W'(1);
                        n_state  = S_POP;
                        if (cmd_in == CMD_POP_FRONT) begin
                            rd_addr = ring_add(r_front, CNT_W'(1));
                            n_front = ring_add(r_front, CNT_W'(1));
                        end else if (r_count >= CNT_W'(2)) begin
                            rd_addr = ring_add(r_front, r_count - CNT_W'(2));
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_cmp && r_rd_key == r_key) begin
                    n_dup = 1'b1;
                end
                if (r_idx != r_count) begin
                    rd_addr = ring_add(r_front, r_idx);
                    n_idx   = r_idx + CNT_W'(1);
                    n_cmp   = 1'b1;
                end else begin
                    n_cmp   = 1'b0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_FIN;
                if (r_dup) begin
                    n_status = ST_DUP;
                    n_halted = 1'b1;
                end else if (r_count == CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                    n_halted = 1'b1;
                end else begin
                    n_status = ST_OK;
                    wr_en    = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                    if (r_cmd == CMD_PUSH_FRONT) begin
                        wr_addr     = front_m1;
                        n_front     = front_m1;
                        n_front_key = r_key;
                        if (r_count == '0) begin
                            n_back_key = r_key;
                        end
                    end else begin
                        wr_addr    = ring_add(r_front, r_count);
                        n_back_key = r_key;
                        if (r_count == '0) begin
                            n_front_key = r_key;
                        end
                    end
                end
            end
            S_POP: begin
                n_state = S_FIN;
                if (r_count == '0) begin
                    n_front_key = '0;
                    n_back_key  = '0;
                end else if (r_cmd == CMD_POP_FRONT) begin
                    n_front_key = r_rd_key;
                end else begin
                    n_back_key = r_rd_key;
                end
            end
            S_FIN: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_tdata = {back_ext[OUT_KEY_W-1:0], front_ext[OUT_KEY_W-1:0],
                                 cnt_ext[COUNT_W-1:0], r_status};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_front_key <= '0;
            r_back_key  <= '0;
            r_idx       <= '0;
            r_cmp       <= 1'b0;
            r_dup       <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_halted    <= n_halted;
            r_front_key <= n_front_key;
            r_back_key  <= n_back_key;
            r_idx       <= n_idx;
            r_cmp       <= n_cmp;
            r_dup       <= n_dup;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_status  <= n_status;
        r_m_tdata <= n_m_tdata;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("held count beyond depth");

    a_empty_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && r_state != S_POP) |-> (r_front_key == '0 && r_back_key == '0))
        else $error("empty queue reports nonzero keys");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan index past held count");

endmodule
